// ===== sv/nre_pkg.sv =====
// ----------------------------------------------------------------------------
// nre_pkg
// Item types, symbol codes and size-class helpers for the node record encoder.
// ----------------------------------------------------------------------------
package nre_pkg;

  typedef struct packed {
    logic [15:0] symbol;
    logic [63:0] children;
    logic [63:0] usage;
    logic [63:0] count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } out_item_t;

  // One field of a record: presence, size class (1/2/4/8 bytes), value.
  typedef struct packed {
    logic        present;
    logic [1:0]  cls;
    logic [63:0] value;
  } slot_t;

  localparam logic [15:0] SYM_ERROR = 16'd0;
  localparam logic [15:0] SYM_FIN   = 16'd1;

  localparam logic FMT_LEGACY  = 1'b0;
  localparam logic FMT_COMPACT = 1'b1;

  localparam int NUM_SLOTS = 5;

  localparam logic [1:0] CLS_1B = 2'd0;
  localparam logic [1:0] CLS_2B = 2'd1;
  localparam logic [1:0] CLS_4B = 2'd2;
  localparam logic [1:0] CLS_8B = 2'd3;

  // Note the strict compares: 255 itself needs two bytes.
  function automatic logic [1:0] size_class(input logic [63:0] v);
    logic [1:0] c;
    if (v < 64'd255) c = CLS_1B;
    else if (v < 64'd65535) c = CLS_2B;
    else if (v < 64'd4294967295) c = CLS_4B;
    else c = CLS_8B;
    return c;
  endfunction

  // Index of the most significant byte for a size class.
  function automatic logic [2:0] top_byte(input logic [1:0] c);
    logic [2:0] t;
    unique case (c)
      CLS_1B:  t = 3'd0;
      CLS_2B:  t = 3'd1;
      CLS_4B:  t = 3'd3;
      default: t = 3'd7;
    endcase
    return t;
  endfunction

endpackage

// ===== sv/node_record_encoder.sv =====
// ----------------------------------------------------------------------------
// node_record_encoder
// Serializes one tree-node record into a byte stream, one byte per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   An item (symbol, children, usage, count) is taken at a clock edge with
//   start high and busy low. The record bytes come out on result, one per
//   cycle, each marked by strobe for exactly one cycle; result.last marks
//   the final byte of a record. In legacy mode a child count above 65535
//   gives one byte 0 with last and error set.
//   The mode register is written through cfg_we/cfg_wdata while idle
//   (1 compact, the reset value; 0 legacy).
// Flow:
//   An accepted item waits in the input register, is then loaded into the
//   byte serializer, and its first byte is then registered onto result.
//   A record has 1 to 29 bytes; the next record follows without a gap. One
//   item waits in the input register, so busy rises only while an item is
//   queued behind the record being sent.
// Reset:
//   Synchronous rst empties the input register and the serializer and sets
//   compact mode. The receiver cannot stall: every strobe is a taken byte.
// ----------------------------------------------------------------------------
module node_record_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  nre_pkg::in_item_t item,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  output logic              strobe,
  output nre_pkg::out_item_t result
);
  import nre_pkg::*;

  logic     format_mode;
  logic     pend_valid;
  in_item_t pend;

  slot_t      slots [NUM_SLOTS];
  slot_t      ld    [NUM_SLOTS];
  logic       ld_err;
  logic       ser_active;
  logic       ser_err;
  logic [2:0] cur;
  logic [2:0] bidx;

  // encode signals
  logic        fin;
  logic        emb;
  logic [63:0] sym64;
  logic [63:0] kids;
  logic [63:0] use_v;
  logic [63:0] cnt;
  logic [7:0]  hdr;
  logic [5:0]  d1, d9, d33, d49, d57;
  logic [31:0] use_sat;
  logic [15:0] cnt_sat;
  logic [15:0] sym_v;

  // serializer signals
  slot_t      cur_slot;
  logic [7:0] byte_sel;
  logic       nxt_found;
  logic [2:0] nxt;
  logic [2:0] nxt_top;
  logic       ser_final;
  logic       load;
  logic       accept;

  // the input register frees up in the same cycle its item moves on
  assign busy   = pend_valid && !load;
  assign accept = start && !busy;

  // ---------------- record layout from the queued item ----------------
  always_comb begin
    sym_v = pend.symbol;
    sym64 = {48'd0, sym_v};
    fin   = (sym_v == SYM_FIN);
    kids  = fin ? 64'd0 : pend.children;
    use_v = (kids == 64'd0) ? 64'd0 : pend.usage;
    cnt   = pend.count;
    d1    = cnt[5:0] - 6'd1;
    d9    = cnt[5:0] - 6'd9;
    d33   = cnt[5:0] - 6'd33;
    d49   = cnt[5:0] - 6'd49;
    d57   = cnt[5:0] - 6'd57;
    hdr   = {size_class(sym64), size_class(kids), size_class(use_v), size_class(cnt)};
    emb   = 1'b0;
    // small leaf counts ride in the header
    if (kids == 64'd0 && cnt != 64'd0) begin
      if (fin) begin
        if (cnt <= 64'd32) begin
          emb = 1'b1;
          hdr = {hdr[7:6], 1'b1, d1[4:0]};
        end else if (cnt <= 64'd48) begin
          emb = 1'b1;
          hdr = {hdr[7:6], 2'b01, d33[3:0]};
        end else if (cnt <= 64'd56) begin
          emb = 1'b1;
          hdr = {hdr[7:6], 3'b001, d49[2:0]};
        end else if (cnt <= 64'd60) begin
          emb = 1'b1;
          hdr = {hdr[7:6], 4'b0001, d57[1:0]};
        end
      end else begin
        if (cnt <= 64'd8) begin
          emb = 1'b1;
          hdr = {hdr[7:4], 1'b1, d1[2:0]};
        end else if (cnt <= 64'd12) begin
          emb = 1'b1;
          hdr = {hdr[7:4], 2'b01, d9[1:0]};
        end
      end
    end

    use_sat = (pend.usage > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pend.usage[31:0];
    cnt_sat = (pend.count > 64'hFFFF) ? 16'hFFFF : pend.count[15:0];

    ld_err = 1'b0;
    if (format_mode == FMT_COMPACT) begin
      ld[0] = '{present: 1'b1, cls: CLS_1B, value: {56'd0, hdr}};
      ld[1] = '{present: 1'b1, cls: size_class(sym64), value: sym64};
      ld[2] = '{present: !fin, cls: size_class(kids), value: kids};
      ld[3] = '{present: !fin && (kids != 64'd0), cls: size_class(use_v), value: use_v};
      ld[4] = '{present: (sym_v != SYM_ERROR) && !emb, cls: size_class(cnt), value: cnt};
    end else if (pend.children > 64'hFFFF) begin
      ld_err = 1'b1;
      ld[0]  = '{present: 1'b1, cls: CLS_1B, value: 64'd0};
      ld[1]  = '{present: 1'b0, cls: CLS_1B, value: 64'd0};
      ld[2]  = '{present: 1'b0, cls: CLS_1B, value: 64'd0};
      ld[3]  = '{present: 1'b0, cls: CLS_1B, value: 64'd0};
      ld[4]  = '{present: 1'b0, cls: CLS_1B, value: 64'd0};
    end else begin
      // little-endian fields: byte-swapped because the serializer sends MSB first
      ld[0] = '{present: 1'b1, cls: CLS_2B, value: {48'd0, sym_v[7:0], sym_v[15:8]}};
      ld[1] = '{present: 1'b1, cls: CLS_4B,
                value: {32'd0, use_sat[7:0], use_sat[15:8], use_sat[23:16], use_sat[31:24]}};
      ld[2] = '{present: 1'b1, cls: CLS_2B, value: {48'd0, cnt_sat[7:0], cnt_sat[15:8]}};
      ld[3] = '{present: 1'b1, cls: CLS_2B,
                value: {48'd0, pend.children[7:0], pend.children[15:8]}};
      ld[4] = '{present: 1'b0, cls: CLS_1B, value: 64'd0};
    end
  end

  // ---------------- byte serializer ----------------
  always_comb begin
    cur_slot  = slots[cur];
    byte_sel  = cur_slot.value[{bidx, 3'b000} +: 8];
    nxt_found = 1'b0;
    nxt       = cur;
    nxt_top   = 3'd0;
    // nearest present field after the current one
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (3'(i) > cur && slots[i].present) begin
        nxt_found = 1'b1;
        nxt       = 3'(i);
        nxt_top   = top_byte(slots[i].cls);
      end
    end
    ser_final = (bidx == 3'd0) && !nxt_found;
    load      = pend_valid && (!ser_active || ser_final);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= FMT_COMPACT;
      pend_valid  <= 1'b0;
      ser_active  <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      if (cfg_we) format_mode <= cfg_wdata;
      strobe <= ser_active;
      if (accept) pend_valid <= 1'b1;
      else if (load) pend_valid <= 1'b0;
      if (load) ser_active <= 1'b1;
      else if (ser_active && ser_final) ser_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pend <= item;
    if (ser_active) begin
      result <= '{out_byte: byte_sel, last: ser_final, error: ser_err};
    end
    if (load) begin
      slots   <= ld;
      ser_err <= ld_err;
      cur     <= 3'd0;
      bidx    <= top_byte(ld[0].cls);
    end else if (ser_active) begin
      if (bidx != 3'd0) begin
        bidx <= bidx - 3'd1;
      end else begin
        cur  <= nxt;
        bidx <= nxt_top;
      end
    end
  end

endmodule

// ===== tb/node_record_encoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// node_record_encoder_test
// Drives node records into the encoder in both layouts and checks every
// output byte, last mark and error flag against an in-bench byte predictor.
// Directed edge records come first, then bursty random traffic across mode
// changes, a full drain pause and a gap-free stretch.
// ----------------------------------------------------------------------------
module node_record_encoder_test;
  import nre_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 40;
  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] MAX16 = 64'h0000_0000_0000_FFFF;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  item;
  logic      cfg_we;
  logic      cfg_wdata;
  logic      strobe;
  out_item_t result;

  out_item_t byte_q[$];     // predicted bytes, oldest first
  out_item_t want;
  logic      fmt_mode;
  int        fails;
  int        items_compact;
  int        items_legacy;
  int        bytes_checked;
  int        quiet_cycles;
  int        burst_left;
  bit        steady;

  node_record_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .strobe   (strobe),
    .result   (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // Bytes needed for a field: strict compares, so 255 already takes two.
  function automatic logic [1:0] width_class(input logic [63:0] v);
    if (v < 64'd255) return CLS_1B;
    if (v < MAX16) return CLS_2B;
    if (v < MAX32) return CLS_4B;
    return CLS_8B;
  endfunction

  function automatic void emit(input logic [7:0] b);
    byte_q.push_back('{out_byte: b, last: 1'b0, error: 1'b0});
  endfunction

  function automatic void emit_be(input logic [1:0] c, input logic [63:0] v);
    int nb = 1 << c;
    for (int i = nb - 1; i >= 0; i--) emit(v[8*i +: 8]);
  endfunction

  function automatic void emit_le(input int nb, input logic [63:0] v);
    for (int i = 0; i < nb; i++) emit(v[8*i +: 8]);
  endfunction

  function automatic void predict_record(input in_item_t it);
    logic [15:0] sym;
    logic [63:0] kids;
    logic [63:0] usg;
    logic [63:0] cnt;
    logic        fin;
    logic        cnt_in_hdr;
    logic [7:0]  hdr;
    sym  = it.symbol;
    kids = it.children;
    usg  = it.usage;
    cnt  = it.count;
    if (fmt_mode == FMT_LEGACY) begin
      items_legacy++;
      if (kids > MAX16) begin
        byte_q.push_back('{out_byte: 8'h00, last: 1'b0, error: 1'b1});
      end else begin
        emit_le(2, {48'd0, sym});
        emit_le(4, (usg > MAX32) ? MAX32 : usg);
        emit_le(2, (cnt > MAX16) ? MAX16 : cnt);
        emit_le(2, kids);
      end
    end else begin
      items_compact++;
      fin = (sym == SYM_FIN);
      if (fin) begin
        kids = '0;
        usg  = '0;
      end
      if (kids == 0) usg = '0;
      hdr = {width_class({48'd0, sym}), width_class(kids), width_class(usg),
             width_class(cnt)};
      cnt_in_hdr = 1'b0;
      // small leaf counts ride in the header's low bits
      if (kids == 0 && cnt != 0) begin
        if (fin) begin
          cnt_in_hdr = 1'b1;
          if (cnt <= 32)      hdr = {hdr[7:6], 6'h20 | 6'(cnt - 1)};
          else if (cnt <= 48) hdr = {hdr[7:6], 6'h10 | 6'(cnt - 33)};
          else if (cnt <= 56) hdr = {hdr[7:6], 6'h08 | 6'(cnt - 49)};
          else if (cnt <= 60) hdr = {hdr[7:6], 6'h04 | 6'(cnt - 57)};
          else cnt_in_hdr = 1'b0;
        end else begin
          cnt_in_hdr = 1'b1;
          if (cnt <= 8)       hdr = {hdr[7:4], 4'h8 | 4'(cnt - 1)};
          else if (cnt <= 12) hdr = {hdr[7:4], 4'h4 | 4'(cnt - 9)};
          else cnt_in_hdr = 1'b0;
        end
      end
      emit(hdr);
      emit_be(width_class({48'd0, sym}), {48'd0, sym});
      if (!fin) begin
        emit_be(width_class(kids), kids);
        if (kids != 0) emit_be(width_class(usg), usg);
      end
      if (sym != SYM_ERROR && !cnt_in_hdr) emit_be(width_class(cnt), cnt);
    end
    byte_q[byte_q.size() - 1].last = 1'b1;
  endfunction

  // ------------------------------------------------------------------ checker

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (byte_q.size() == 0) begin
        $display("%0t: unexpected byte %02h last %0b error %0b", $time,
                 result.out_byte, result.last, result.error);
        fails++;
      end else begin
        want = byte_q.pop_front();
        if (result !== want) begin
          $display({"%0t: byte mismatch: expected %02h last %0b error %0b, ",
                    "got %02h last %0b error %0b"},
                   $time, want.out_byte, want.last, want.error,
                   result.out_byte, result.last, result.error);
          fails++;
        end
        bytes_checked++;
      end
    end
  end

  // quiet cycles: neither an accepted item nor a byte
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (strobe || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: watchdog expired, %0d bytes still expected", $time, byte_q.size());
    $display("node_record_encoder_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic in_item_t mk_node(input logic [15:0] sym, input logic [63:0] kids,
                                       input logic [63:0] usg, input logic [63:0] cnt);
    in_item_t it;
    it.symbol   = sym;
    it.children = kids;
    it.usage    = usg;
    it.count    = cnt;
    return it;
  endfunction

  function automatic logic [63:0] rand_wide();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'($urandom_range(0, 15));
      1: v = 64'($urandom_range(0, 254));
      2: begin
        case ($urandom_range(0, 9))
          0: v = 64'd254;
          1: v = 64'd255;
          2: v = 64'd256;
          3: v = MAX16 - 1;
          4: v = MAX16;
          5: v = MAX16 + 1;
          6: v = MAX32 - 1;
          7: v = MAX32;
          8: v = MAX32 + 1;
          default: v = MAX64;
        endcase
      end
      3: v = 64'($urandom_range(0, 65535));
      4: v = 64'($urandom);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic in_item_t gen_node(input bit legacy);
    in_item_t it;
    case ($urandom_range(0, 9))
      0: it.symbol = SYM_ERROR;
      1: it.symbol = SYM_FIN;
      2: it.symbol = 16'($urandom_range(2, 300));
      default: it.symbol = 16'($urandom);
    endcase
    if (legacy)
      it.children = ($urandom_range(0, 4) == 0) ? rand_wide()
                                                : 64'($urandom_range(0, 65535));
    else
      it.children = ($urandom_range(0, 9) < 4) ? 64'd0 : rand_wide();
    it.usage = rand_wide();
    it.count = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 64)) : rand_wide();
    return it;
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) @(negedge clk) start <= 1'b0;
  endtask

  // start stays high after acceptance so back-to-back items need no toggle
  task automatic send_node(input in_item_t it);
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_record(it);
  endtask

  task automatic pace();
    if (!steady) begin
      if (burst_left == 0) begin
        idle_cycles($urandom_range(1, 15));
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk) start <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    fmt_mode = m;
  endtask

  task automatic test_compact_edges();
    write_mode(FMT_COMPACT);
    send_node(mk_node(SYM_ERROR, 0, 0, 0));
    send_node(mk_node(SYM_ERROR, 0, 5, 7));            // count in header, no count bytes
    send_node(mk_node(SYM_ERROR, 3, 300, 70000));
    send_node(mk_node(SYM_FIN, 0, 0, 1));
    send_node(mk_node(SYM_FIN, 0, 0, 48));
    send_node(mk_node(SYM_FIN, 0, 0, 49));
    send_node(mk_node(SYM_FIN, 0, 0, 60));
    send_node(mk_node(SYM_FIN, 5, 9, 61));             // FIN drops children and usage
    send_node(mk_node(16'd254, 0, 0, 8));
    send_node(mk_node(16'd255, 0, 0, 9));
    send_node(mk_node(16'hFFFF, 0, 0, 12));
    send_node(mk_node(16'hFFFE, 0, 77, 13));           // leaf usage dropped
    send_node(mk_node(16'd2, MAX64, MAX64, MAX64));
    send_node(mk_node(16'd1000, 255, MAX16, MAX32));
    send_node(mk_node(16'd7, 254, MAX16 - 1, MAX32 - 1));
    send_node(mk_node(16'd300, 0, 12345, 0));
  endtask

  task automatic test_legacy_edges();
    write_mode(FMT_LEGACY);
    send_node(mk_node(16'hFFFF, 65535, MAX32 + 1, 65536));
    send_node(mk_node(16'h1234, 65536, 5, 5));         // too many children
    send_node(mk_node(16'd7, MAX64, MAX64, MAX64));
    send_node(mk_node(SYM_ERROR, 0, 0, 0));
    send_node(mk_node(SYM_FIN, 300, MAX32, MAX16));
    send_node(mk_node(16'hA55A, 12, MAX64, MAX64));
  endtask

  task automatic test_random_traffic(input logic m, input int n);
    write_mode(m);
    repeat (n) begin
      pace();
      send_node(gen_node(m == FMT_LEGACY));
    end
  endtask

  task automatic test_drain_pause();
    write_mode(FMT_COMPACT);
    repeat (10) begin
      pace();
      send_node(gen_node(1'b0));
    end
    wait_drained();
    repeat (10) begin
      pace();
      send_node(gen_node(1'b0));
    end
  endtask

  task automatic test_no_gaps(input logic m, input int n);
    steady = 1'b1;
    test_random_traffic(m, n);
    steady = 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    item          = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    fmt_mode      = FMT_COMPACT;
    fails         = 0;
    items_compact = 0;
    items_legacy  = 0;
    bytes_checked = 0;
    burst_left    = 0;
    steady        = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_compact_edges();
    test_legacy_edges();
    test_random_traffic(FMT_COMPACT, 50);
    test_random_traffic(FMT_LEGACY, 40);
    test_drain_pause();
    test_no_gaps(FMT_LEGACY, 15);
    test_no_gaps(FMT_COMPACT, 15);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d compact and %0d legacy records, %0d bytes checked",
             items_compact, items_legacy, bytes_checked);
    $display("edge sizes, embedded counts, FIN/ERROR forms, legacy overflow, %0d failures",
             fails);
    if (fails == 0 && byte_q.size() == 0) begin
      $display("node_record_encoder_test: clean");
    end else begin
      $display("node_record_encoder_test: errors");
    end
    $finish;
  end

endmodule
